// ===== rtl/core/ilna_pkg.sv =====
// Shared types, constants and helpers for the icosahedral lattice neighbor address block.
package ilna_pkg;

    localparam int MAX_L        = 64;
    localparam int L_W          = 7;   // holds 1..MAX_L
    localparam int COORD_W      = 6;
    localparam int NCOORD_W     = 7;
    localparam int PATCH_W      = 4;
    localparam int INDEX_W      = 16;
    localparam int ROW_W        = 10;  // patch*L + y, at most 10*64
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [L_W-1:0]     L_RESET      = L_W'(2);
    localparam logic [PATCH_W-1:0] HALF_PATCHES = PATCH_W'(5);
    localparam logic [PATCH_W-1:0] LAST_PATCH   = PATCH_W'(9);
    localparam logic [PATCH_W-1:0] PATCH_SOUTH  = PATCH_W'(10);
    localparam logic [PATCH_W-1:0] PATCH_NORTH  = PATCH_W'(11);
    localparam logic [NCOORD_W-1:0] COORD_POLE  = '1;  // -1

    typedef enum logic [1:0] {
        KIND_PLUS_X = 2'd0,
        KIND_PLUS_Y = 2'd1,
        KIND_PLUS_Z = 2'd2
    } kind_t;

    // Classified request, front to back
    typedef struct packed {
        logic [NCOORD_W-1:0] nx;
        logic [NCOORD_W-1:0] ny;
        logic [PATCH_W-1:0]  ns;
        logic                bad;
    } step_t;

    // Clamp the size register to 1..MAX_L
    function automatic logic [L_W-1:0] eff_size(input logic [L_W-1:0] v);
        logic [L_W-1:0] r;
        if (v == '0)
            r = L_W'(1);
        else if (v > L_W'(MAX_L))
            r = L_W'(MAX_L);
        else
            r = v;
        return r;
    endfunction

endpackage

// ===== rtl/core/icosahedral_lattice_neighbor_address_top.sv =====
// Top level of the icosahedral lattice neighbor address generator.
// Path: a request accepted on s_tvalid/s_tready passes the queue write, the row product
//   stage and the index product stage / output register before it shows on m_tvalid.
// Throughput: one request per cycle while m_tready stays high; the four-entry queue and the output
//   register let the input side keep taking requests while a result waits.
// Reset (rst_n low, asynchronous): queue and pipeline empty, lattice size back to 2.
module icosahedral_lattice_neighbor_address_top (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: lattice size L
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // site_x[5:0], site_y[11:6], site_patch[15:12]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // next_x[6:0], next_y[13:7], next_patch[17:14],
                                   // next_index[33:18], zero[39:34]
    output logic [0:0]  m_tuser    // bad_input[0]
);
    import ilna_pkg::*;

    logic [L_W-1:0]     size_reg;
    logic [L_W-1:0]     size_next;
    logic [L_W-1:0]     l_eff;

    step_t              front_step;
    logic               q_full;
    logic               q_not_empty;
    step_t              q_step;
    logic               push;
    logic               pop;

    step_t              res_step;
    logic [INDEX_W-1:0] res_index;

    // Size register; the clamp keeps L within 1..MAX_L everywhere downstream
    assign size_next = cfg_we ? cfg_wdata : size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= L_RESET;
        else
            size_reg <= size_next;
    end

    assign l_eff = eff_size(size_reg);

    // Front end classifies in the accepting cycle and writes the queue
    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;

    ilna_front u_front (
        .kind       (s_tuser),
        .site_x     (s_tdata[5:0]),
        .site_y     (s_tdata[11:6]),
        .site_patch (s_tdata[15:12]),
        .l_eff      (l_eff),
        .step       (front_step)
    );

    ilna_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_step),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_data  (q_step)
    );

    // Back end drains the queue and computes the linear index
    ilna_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .l_eff     (l_eff),
        .in_valid  (q_not_empty),
        .in_step   (q_step),
        .in_take   (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_step  (res_step),
        .out_index (res_index)
    );

    assign m_tdata = {6'b0, res_index, res_step.ns, res_step.ny, res_step.nx};
    assign m_tuser = res_step.bad;

endmodule

// ===== rtl/core/ilna_front.sv =====
// Front end: checks a request and resolves the neighbor site across patch edges.
module ilna_front (
    input  logic [1:0]                    kind,
    input  logic [ilna_pkg::COORD_W-1:0]  site_x,
    input  logic [ilna_pkg::COORD_W-1:0]  site_y,
    input  logic [ilna_pkg::PATCH_W-1:0]  site_patch,
    input  logic [ilna_pkg::L_W-1:0]      l_eff,
    output ilna_pkg::step_t               step
);
    import ilna_pkg::*;

    logic [L_W-1:0]      x7;
    logic [L_W-1:0]      y7;
    logic [L_W-1:0]      last;
    logic                south;
    logic                x_last;
    logic                y_last;
    logic                bad;
    logic [PATCH_W-1:0]  s_next_south;  // (s+1)%5 for southern s
    logic [PATCH_W-1:0]  s_down_north;  // (s-4)%5 for northern s
    logic [PATCH_W-1:0]  s_next_north;  // (s+1)%5+5 for northern s
    logic [NCOORD_W-1:0] nx;
    logic [NCOORD_W-1:0] ny;
    logic [PATCH_W-1:0]  ns;

    assign x7     = {1'b0, site_x};
    assign y7     = {1'b0, site_y};
    assign last   = l_eff - L_W'(1);
    assign south  = site_patch < HALF_PATCHES;
    assign x_last = x7 == last;
    assign y_last = y7 == last;
    assign bad    = (x7 >= l_eff) || (y7 >= l_eff) || (site_patch > LAST_PATCH)
                    || !(kind == KIND_PLUS_X || kind == KIND_PLUS_Y || kind == KIND_PLUS_Z);

    assign s_next_south = (site_patch == HALF_PATCHES - PATCH_W'(1)) ? '0
                        : site_patch + PATCH_W'(1);
    assign s_down_north = (site_patch == LAST_PATCH) ? '0
                        : site_patch - (HALF_PATCHES - PATCH_W'(1));
    assign s_next_north = (site_patch == LAST_PATCH) ? HALF_PATCHES
                        : site_patch + PATCH_W'(1);

    always_comb
    begin
        nx = x7 + NCOORD_W'(1);
        ny = y7;
        ns = site_patch;
        case (kind_t'(kind))
            KIND_PLUS_X:
            begin
                if (x_last)
                begin
                    if (south && site_y == '0)
                    begin
                        nx = COORD_POLE; ny = COORD_POLE; ns = PATCH_SOUTH;
                    end
                    else if (south)
                    begin
                        nx = y7; ny = '0; ns = s_next_south;
                    end
                    else
                    begin
                        nx = '0; ny = y7; ns = s_down_north;
                    end
                end
            end
            KIND_PLUS_Y:
            begin
                nx = x7;
                ny = y7 + NCOORD_W'(1);
                if (y_last)
                begin
                    if (south)
                    begin
                        ny = '0; ns = site_patch + HALF_PATCHES;
                    end
                    else if (site_x == '0)
                    begin
                        nx = COORD_POLE; ny = COORD_POLE; ns = PATCH_NORTH;
                    end
                    else
                    begin
                        nx = '0; ny = l_eff - x7; ns = s_next_north;
                    end
                end
            end
            KIND_PLUS_Z:
            begin
                ny = y7 + NCOORD_W'(1);
                if (south && x_last)
                begin
                    nx = last - y7; ny = '0; ns = s_next_south;
                end
                else if (south && y_last)
                begin
                    ny = '0; ns = site_patch + HALF_PATCHES;
                end
                else if (!south && y_last)
                begin
                    nx = '0; ny = last - x7; ns = s_next_north;
                end
                else if (!south && x_last)
                begin
                    nx = '0; ns = s_down_north;
                end
            end
            default:
            begin
                nx = '0; ny = '0; ns = '0;
            end
        endcase
        if (bad)
        begin
            nx = '0; ny = '0; ns = '0;
        end
    end

    assign step = '{nx: nx, ny: ny, ns: ns, bad: bad};

endmodule

// ===== rtl/core/ilna_queue.sv =====
// Short register queue between the front end and the index back end.
module ilna_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ilna_pkg::step_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output ilna_pkg::step_t pop_data
);
    import ilna_pkg::*;

    step_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full      = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/core/ilna_back.sv =====
// Back end: two-stage linear index computation, (patch*L + y)*L + x, with output register.
module ilna_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ilna_pkg::L_W-1:0]      l_eff,
    input  logic                          in_valid,
    input  ilna_pkg::step_t               in_step,
    output logic                          in_take,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ilna_pkg::step_t               out_step,
    output logic [ilna_pkg::INDEX_W-1:0]  out_index
);
    import ilna_pkg::*;

    localparam int PROD1_W = PATCH_W + L_W;
    localparam int PROD2_W = ROW_W + L_W;

    logic                s1_vld_reg;
    logic                s1_vld_next;
    step_t               s1_step_reg;
    logic [ROW_W-1:0]    s1_row_reg;
    logic [COORD_W-1:0]  s1_col_reg;
    logic                s2_vld_reg;
    logic                s2_vld_next;
    step_t               s2_step_reg;
    logic [INDEX_W-1:0]  s2_index_reg;

    logic                s1_load;
    logic                s2_load;
    logic                pole;
    logic [PATCH_W-1:0]  ip;
    logic [COORD_W-1:0]  iy;
    logic [COORD_W-1:0]  ix;
    logic [PROD1_W-1:0]  prod1;
    logic [PROD2_W-1:0]  prod2;

    assign s2_load = !s2_vld_reg || out_ready;
    assign s1_load = !s1_vld_reg || s2_load;
    assign in_take = in_valid && s1_load;

    // Poles: south is 10*L*L, north is 10*L*L + 1
    assign pole  = in_step.ns == PATCH_SOUTH || in_step.ns == PATCH_NORTH;
    assign ip    = pole ? PATCH_SOUTH : in_step.ns;
    assign iy    = pole ? '0 : in_step.ny[COORD_W-1:0];
    assign ix    = (in_step.ns == PATCH_NORTH) ? COORD_W'(1)
                 : (pole ? '0 : in_step.nx[COORD_W-1:0]);
    assign prod1 = ip * l_eff;
    assign prod2 = s1_row_reg * l_eff;

    always_comb
    begin
        s1_vld_next = s1_load ? in_valid : s1_vld_reg;
        s2_vld_next = s2_load ? s1_vld_reg : s2_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_step_reg <= in_step;
            s1_row_reg  <= ROW_W'(prod1 + PROD1_W'(iy));
            s1_col_reg  <= ix;
        end
        if (s2_load && s1_vld_reg)
        begin
            s2_step_reg  <= s1_step_reg;
            s2_index_reg <= INDEX_W'(prod2 + PROD2_W'(s1_col_reg));
        end
    end

    assign out_valid = s2_vld_reg;
    assign out_step  = s2_step_reg;
    assign out_index = s2_index_reg;

endmodule

// ===== rtl/core/ilna_checker.sv =====
// Port-level checker for the neighbor address top level, with its bind.
module ilna_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [0:0]  m_tuser
);
    import ilna_pkg::*;

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Rejected requests carry an all-zero payload
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[33:0] == 34'd0)
        else $error("rejected request with nonzero payload");

    // Pole results carry -1 coordinates
    a_pole: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0]
        && (m_tdata[17:14] == PATCH_SOUTH || m_tdata[17:14] == PATCH_NORTH)
        |-> m_tdata[6:0] == COORD_POLE && m_tdata[13:7] == COORD_POLE)
        else $error("pole result without -1 coordinates");

    // Patch number and padding stay in range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[17:14] <= PATCH_NORTH && m_tdata[39:34] == 6'd0)
        else $error("patch or padding out of range");

endmodule

bind icosahedral_lattice_neighbor_address_top ilna_checker u_ilna_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
